FILE: hw/rtl/pipd_pkg.sv
// Shared types, constants and table functions of the packed image decoder.
package pipd_pkg;

  localparam int MaxRowLength = 4096;
  localparam int StoreDepth   = MaxRowLength + 1;
  localparam int SlotBits     = $clog2(StoreDepth);
  localparam int IndexBits    = 24;
  localparam int BufferBits   = 64;
  localparam int HeldBits     = 7;

  localparam logic [1:0] CfgFormatVersion = 2'd0;
  localparam logic [1:0] CfgRowLength     = 2'd1;
  localparam logic [1:0] CfgPixelCount    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PULL,
    OP_RESTART
  } op_e;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_FULL    = 3'd2,
    ST_NEED    = 3'd3,
    ST_DONE    = 3'd4,
    ST_BADW    = 3'd5,
    ST_RESTART = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD1,
    BK_RD2,
    BK_RD3
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [1:0]  format_version;
    logic [12:0] row_length;
    logic [24:0] pixel_count;
  } cfg_t;

  function automatic logic [5:0] width_v1(input logic [2:0] code);
    logic [5:0] w;
    unique case (code)
      3'd0:    w = 6'd0;
      3'd1:    w = 6'd4;
      3'd2:    w = 6'd5;
      3'd3:    w = 6'd6;
      3'd4:    w = 6'd7;
      3'd5:    w = 6'd8;
      3'd6:    w = 6'd16;
      default: w = 6'd32;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] width_v2(input logic [3:0] code);
    logic [5:0] w;
    unique case (code)
      4'd0:    w = 6'd0;
      4'd13:   w = 6'd16;
      4'd14:   w = 6'd32;
      4'd15:   w = 6'd0;
      default: w = 6'(code) + 6'd3;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] count_v1(input logic [2:0] code);
    return 16'(1) << code;
  endfunction

  function automatic logic [SlotBits-1:0] wrap_slot(input logic [SlotBits:0] x);
    logic [SlotBits:0] r;
    r = (x >= (SlotBits+1)'(StoreDepth)) ? x - (SlotBits+1)'(StoreDepth) : x;
    return r[SlotBits-1:0];
  endfunction

endpackage

FILE: hw/rtl/pipd_if.sv
// Stream interfaces for the decoder's input beats and result beats.
interface pipd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_value;
  modport source (output valid, output action, output byte_value, input ready);
  modport sink (input valid, input action, input byte_value, output ready);
endinterface

interface pipd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] pixel_value;
  logic [23:0] pixel_index;
  logic        last_pixel;
  modport source (output valid, output status, output pixel_value, output pixel_index,
                  output last_pixel, input ready);
  modport sink (input valid, input status, input pixel_value, input pixel_index,
                input last_pixel, output ready);
endinterface

FILE: hw/rtl/pipd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pipd_ram #(
  parameter int Width = 16,
  parameter int Depth = 4097
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/pipd_front.sv
// Front part: accepts input beats, decodes the action and queues them.
module pipd_front import pipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pipd_in_if.sink     in_if,
  output q_head_t     head_o,
  input  logic        pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      item_in;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid & in_if.ready;

  always_comb begin
    item_in.byte_value = in_if.byte_value;
    if (in_if.action[1]) begin
      item_in.op = OP_RESTART;
    end else if (in_if.action[0]) begin
      item_in.op = OP_PULL;
    end else begin
      item_in.op = OP_LOAD;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: hw/rtl/pipd_back.sv
// Back part: bit buffer, block header decode, prediction and the result register.
module pipd_back import pipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  q_head_t     head_i,
  output logic        pop_o,
  pipd_out_if.source  out_if
);

  back_state_e state_q, state_d;

  logic [BufferBits-1:0] buf_q, buf_d;
  logic [HeldBits-1:0]   held_q, held_d;
  logic [15:0]           left_q, left_d;
  logic [5:0]            width_q, width_d;
  logic [IndexBits-1:0]  idx_q, idx_d;
  logic [SlotBits-1:0]   slot_q, slot_d;
  logic [15:0]           prev_q, prev_d;
  logic [15:0]           diff_q, diff_d;
  logic signed [18:0]    sum_q, sum_d;
  logic [IndexBits-1:0]  cur_idx_q, cur_idx_d;
  logic [SlotBits-1:0]   cur_slot_q, cur_slot_d;

  logic                  ovalid_q, ovalid_d;
  status_e               ostatus_q, ostatus_d;
  logic [15:0]           ovalue_q, ovalue_d;
  logic [IndexBits-1:0]  oindex_q, oindex_d;
  logic                  olast_q, olast_d;

  logic                  ram_we;
  logic [SlotBits-1:0]   ram_waddr, ram_raddr;
  logic [15:0]           ram_wdata, ram_rdata;

  logic                  out_free, go;
  logic [12:0]           rl;
  logic [24:0]           limit;
  logic                  v2, header_due, bad, need, done;
  logic [HeldBits-1:0]   hbits, used;
  logic [3:0]            cc, wc;
  logic [15:0]           count;
  logic [5:0]            width;
  logic [BufferBits-1:0] shifted;
  logic [32:0]           mask33;
  logic [31:0]           raw;
  logic [15:0]           diff16;
  logic                  predict;
  logic [SlotBits:0]     base;
  logic [SlotBits:0]     slot_inc;
  logic signed [18:0]    total;
  logic signed [18:0]    avg;
  logic [15:0]           pix_final;

  assign out_free = !ovalid_q || out_if.ready;
  assign go       = head_i.valid && out_free;

  always_comb begin
    rl = cfg_i.row_length;
    if (rl == 13'd0) begin
      rl = 13'd1;
    end else if (rl > 13'(MaxRowLength)) begin
      rl = 13'(MaxRowLength);
    end
    limit = (cfg_i.pixel_count > (25'(1) << IndexBits)) ? (25'(1) << IndexBits)
                                                         : cfg_i.pixel_count;
  end

  always_comb begin
    v2         = (cfg_i.format_version == 2'd2);
    header_due = (left_q == 16'd0);
    cc         = v2 ? buf_q[3:0] : {1'b0, buf_q[2:0]};
    wc         = v2 ? buf_q[7:4] : {1'b0, buf_q[5:3]};
    if (header_due) begin
      hbits = v2 ? 7'd8 : 7'd6;
      count = v2 ? (16'(1) << cc) : count_v1(cc[2:0]);
      width = v2 ? width_v2(wc) : width_v1(wc[2:0]);
      bad   = v2 && (wc == 4'd15);
    end else begin
      hbits = 7'd0;
      count = left_q;
      width = width_q;
      bad   = 1'b0;
    end
    done    = ({1'b0, idx_q} >= limit);
    used    = hbits + 7'(width);
    need    = (held_q < hbits) || (!bad && (held_q < used));
    shifted = buf_q >> hbits;
    mask33  = (33'(1) << width) - 33'(1);
    raw     = shifted[31:0] & mask33[31:0];
    diff16  = raw[15:0];
    if ((width != 6'd0) && (width < 6'd16) && raw[5'(width - 6'd1)]) begin
      diff16 = diff16 | ~mask33[15:0];
    end
    predict  = (idx_q > 24'(rl));
    base     = (SlotBits+1)'(cur_slot_q) + (SlotBits+1)'(StoreDepth)
             - (SlotBits+1)'(rl) - (SlotBits+1)'(1);
    slot_inc = (SlotBits+1)'(slot_q) + (SlotBits+1)'(1);
    total    = sum_q + 19'(signed'(ram_rdata));
    avg      = (total < 0) ? ((total + 19'sd3) >>> 2) : (total >>> 2);
    pix_final = diff_q + avg[15:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (go && head_i.item.op == OP_PULL && !done && !need && !bad && predict) begin
          state_d = BK_RD1;
        end
      end
      BK_RD1:  state_d = BK_RD2;
      BK_RD2:  state_d = BK_RD3;
      BK_RD3: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    buf_d      = buf_q;
    held_d     = held_q;
    left_d     = left_q;
    width_d    = width_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    prev_d     = prev_q;
    diff_d     = diff_q;
    sum_d      = sum_q;
    cur_idx_d  = cur_idx_q;
    cur_slot_d = cur_slot_q;
    ovalid_d   = ovalid_q && !out_if.ready;
    ostatus_d  = ostatus_q;
    ovalue_d   = ovalue_q;
    oindex_d   = oindex_q;
    olast_d    = olast_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur_slot_q;
    ram_wdata  = pix_final;
    ram_raddr  = wrap_slot(base);

    unique case (state_q)
      BK_IDLE: begin
        if (go) begin
          pop_o     = 1'b1;
          ovalid_d  = 1'b1;
          ovalue_d  = 16'd0;
          oindex_d  = '0;
          olast_d   = 1'b0;
          unique case (head_i.item.op)
            OP_LOAD: begin
              if (held_q > 7'(BufferBits - 8)) begin
                ostatus_d = ST_FULL;
              end else begin
                buf_d     = buf_q | (BufferBits'(head_i.item.byte_value) << held_q);
                held_d    = held_q + 7'd8;
                ostatus_d = ST_TAKEN;
              end
            end
            OP_RESTART: begin
              buf_d     = '0;
              held_d    = '0;
              left_d    = '0;
              width_d   = '0;
              idx_d     = '0;
              slot_d    = '0;
              ostatus_d = ST_RESTART;
            end
            default: begin
              if (done) begin
                ostatus_d = ST_DONE;
              end else if (need) begin
                ostatus_d = ST_NEED;
              end else if (bad) begin
                ostatus_d = ST_BADW;
              end else begin
                buf_d      = buf_q >> used;
                held_d     = held_q - used;
                width_d    = width;
                left_d     = count - 16'd1;
                idx_d      = idx_q + 24'd1;
                slot_d     = (slot_q == SlotBits'(StoreDepth - 1)) ? '0
                                                                     : slot_inc[SlotBits-1:0];
                cur_idx_d  = idx_q;
                cur_slot_d = slot_q;
                diff_d     = diff16;
                if (predict) begin
                  ovalid_d  = 1'b0;
                  ram_raddr = wrap_slot((SlotBits+1)'(slot_q) + (SlotBits+1)'(StoreDepth)
                                        - (SlotBits+1)'(rl) - (SlotBits+1)'(1));
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_q;
                  ram_wdata = (idx_q == '0) ? diff16 : diff16 + prev_q;
                  prev_d    = ram_wdata;
                  ostatus_d = ST_PIXEL;
                  ovalue_d  = ram_wdata;
                  oindex_d  = idx_q;
                  olast_d   = ({1'b0, idx_q} + 25'd1 == limit);
                end
              end
            end
          endcase
        end
      end
      BK_RD1: begin
        sum_d     = 19'(signed'(prev_q)) + 19'(signed'(ram_rdata)) + 19'sd2;
        ram_raddr = wrap_slot(base + (SlotBits+1)'(1));
      end
      BK_RD2: begin
        sum_d     = total;
        ram_raddr = wrap_slot(base + (SlotBits+1)'(2));
      end
      BK_RD3: begin
        ram_raddr = wrap_slot(base + (SlotBits+1)'(2));
        if (out_free) begin
          ram_we    = 1'b1;
          prev_d    = pix_final;
          ovalid_d  = 1'b1;
          ostatus_d = ST_PIXEL;
          ovalue_d  = pix_final;
          oindex_d  = cur_idx_q;
          olast_d   = ({1'b0, cur_idx_q} + 25'd1 == limit);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      buf_q    <= '0;
      held_q   <= '0;
      left_q   <= '0;
      width_q  <= '0;
      idx_q    <= '0;
      slot_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      buf_q    <= buf_d;
      held_q   <= held_d;
      left_q   <= left_d;
      width_q  <= width_d;
      idx_q    <= idx_d;
      slot_q   <= slot_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    diff_q     <= diff_d;
    sum_q      <= sum_d;
    cur_idx_q  <= cur_idx_d;
    cur_slot_q <= cur_slot_d;
    ostatus_q  <= ostatus_d;
    ovalue_q   <= ovalue_d;
    oindex_q   <= oindex_d;
    olast_q    <= olast_d;
  end

  pipd_ram #(
    .Width (16),
    .Depth (StoreDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_if.valid       = ovalid_q;
  assign out_if.status      = ostatus_q;
  assign out_if.pixel_value = ovalue_q;
  assign out_if.pixel_index = oindex_q;
  assign out_if.last_pixel  = olast_q;

endmodule

FILE: hw/rtl/packed_image_predictive_decoder.sv
// Top level of the packed image decoder: configuration registers, front and back parts.
//
//   port       dir   beat contents
//   in_if      in    action, byte_value
//   out_if     out   status, pixel_value, pixel_index, last_pixel
//   cfg_*      in    format_version, row_length, pixel_count writes
//
// Loads, restarts, non-pixel pulls and pixels without the average complete in the idle state.
// A pixel that uses the four-neighbour average passes through BK_RD1, BK_RD2 and BK_RD3,
// set by the three reads through the single read port of the line store.
// Reset clears control state; the line store holds no defined contents until written.
// A two-beat queue sits between the input and the back part, so input beats are
// accepted while a result waits on a stalled output.
module packed_image_predictive_decoder import pipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pipd_in_if.sink     in_if,
  pipd_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  cfg_t    cfg_q;
  q_head_t head;
  logic    pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_version <= 2'd1;
      cfg_q.row_length     <= 13'(MaxRowLength);
      cfg_q.pixel_count    <= 25'(1) << IndexBits;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgFormatVersion) begin
        cfg_q.format_version <= cfg_data_i[1:0];
      end
      if (cfg_index_i == CfgRowLength) begin
        cfg_q.row_length <= cfg_data_i[12:0];
      end
      if (cfg_index_i == CfgPixelCount) begin
        cfg_q.pixel_count <= cfg_data_i;
      end
    end
  end

  pipd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .head_o (head),
    .pop_i  (pop)
  );

  pipd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_if (out_if)
  );

endmodule

FILE: hw/rtl/pipd_checker.sv
// Port-level checks of the packed image decoder and their binding.
module pipd_checker import pipd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_value,
  input logic [23:0] out_index,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value)
      && $stable(out_index) && $stable(out_last))
    else $error("Stalled result beat changed.");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status != ST_PIXEL) |-> (out_value == 16'd0) && (out_index == 24'd0)
      && !out_last)
    else $error("Non-pixel beat carries pixel fields.");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("Result beat offered during reset.");

endmodule

bind packed_image_predictive_decoder pipd_checker u_pipd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_value  (out_if.pixel_value),
  .out_index  (out_if.pixel_index),
  .out_last   (out_if.last_pixel)
);
